@@ src/tps_pkg.sv @@
package tps_pkg;

    localparam int VALUE_BITS = 16;
    localparam int IN_BITS    = 16;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);

    typedef struct packed {
        logic load_n;     // capture the request's number
        logic init_p;     // candidate p starts at two
        logic inc_p;      // advance the candidate
        logic load_v_p;   // value under test becomes p
        logic load_v_np;  // value under test becomes n - p
        logic init_div;   // trial divisor starts at two
        logic next_div;   // advance the trial divisor and its square
        logic start_rem;  // begin a remainder calculation
        logic step_rem;   // one restoring remainder step
    } dp_cmd_t;

    typedef struct packed {
        logic n_small;    // n below four
        logic n_odd;
        logic v_small;    // value under test below two
        logic sq_over;    // divisor squared exceeds the value
        logic rem_last;   // final remainder step in progress
        logic rem_zero;
        logic p_end;      // candidate beyond n - 2
    } dp_status_t;

endpackage

@@ src/tps_datapath.sv @@
module tps_datapath (
    input  logic                        clk,
    input  logic [tps_pkg::IN_BITS-1:0] target_number,
    input  tps_pkg::dp_cmd_t            cmd,
    output tps_pkg::dp_status_t         status
);
    import tps_pkg::*;

    logic [VALUE_BITS-1:0]          n_reg;
    logic [VALUE_BITS-1:0]          p_reg;
    logic [VALUE_BITS-1:0]          v_reg;
    logic [VALUE_BITS-1:0]          d_reg;
    logic [VALUE_BITS+1:0]          sq_reg;
    logic [VALUE_BITS:0]            rem_reg;
    logic [VALUE_BITS-1:0]          quo_reg;
    logic [CNT_BITS-1:0]            cnt_reg;

    logic [VALUE_BITS+IN_BITS-1:0]  in_wide;
    logic [VALUE_BITS:0]            rem_shift;
    logic [VALUE_BITS:0]            rem_sub;
    logic                           rem_ge;

    assign in_wide   = {{VALUE_BITS{1'b0}}, target_number};
    assign rem_shift = {rem_reg[VALUE_BITS-1:0], quo_reg[VALUE_BITS-1]};
    assign rem_ge    = (rem_shift >= {1'b0, d_reg});
    assign rem_sub   = rem_shift - {1'b0, d_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_n)
        begin
            n_reg <= in_wide[VALUE_BITS-1:0];
        end
        if (cmd.init_p)
        begin
            p_reg <= VALUE_BITS'(2);
        end
        else if (cmd.inc_p)
        begin
            p_reg <= p_reg + VALUE_BITS'(1);
        end
        if (cmd.load_v_p)
        begin
            v_reg <= p_reg;
        end
        else if (cmd.load_v_np)
        begin
            v_reg <= n_reg - p_reg;
        end
        if (cmd.init_div)
        begin
            d_reg  <= VALUE_BITS'(2);
            sq_reg <= (VALUE_BITS+2)'(4);
        end
        else if (cmd.next_div)
        begin
            // (d + 1)^2 = d^2 + 2d + 1
            d_reg  <= d_reg + VALUE_BITS'(1);
            sq_reg <= sq_reg + {1'b0, d_reg, 1'b1};
        end
        if (cmd.start_rem)
        begin
            rem_reg <= '0;
            quo_reg <= v_reg;
            cnt_reg <= '0;
        end
        else if (cmd.step_rem)
        begin
            rem_reg <= rem_ge ? rem_sub : rem_shift;
            quo_reg <= {quo_reg[VALUE_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg + CNT_BITS'(1);
        end
    end

    always_comb
    begin
        status.n_small  = (n_reg < VALUE_BITS'(4));
        status.n_odd    = n_reg[0];
        status.v_small  = (v_reg < VALUE_BITS'(2));
        status.sq_over  = (sq_reg > {2'b00, v_reg});
        status.rem_last = (cnt_reg == CNT_BITS'(VALUE_BITS-1));
        status.rem_zero = (rem_reg == '0);
        status.p_end    = (p_reg > (n_reg - VALUE_BITS'(2)));
    end

endmodule

@@ src/tps_control.sv @@
module tps_control (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tps_pkg::dp_status_t status,
    output tps_pkg::dp_cmd_t    cmd,
    output logic                busy,
    output logic                done,
    output logic                answer
);
    import tps_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_CLASSIFY = 9'b000000010,
        S_LOAD_V1  = 9'b000000100,
        S_LOAD_V2  = 9'b000001000,
        S_TEST     = 9'b000010000,
        S_BOUND    = 9'b000100000,
        S_DIV      = 9'b001000000,
        S_REM_CHK  = 9'b010000000,
        S_NEXT_P   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   second_reg, second_next;
    logic   done_reg, done_next;
    logic   answer_reg, answer_next;
    logic   is_prime, is_composite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        answer_reg <= answer_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        second_next  = second_reg;
        done_next    = 1'b0;
        answer_next  = answer_reg;
        cmd          = '0;
        is_prime     = 1'b0;
        is_composite = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_n = 1'b1;
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                if (status.n_small)
                begin
                    done_next   = 1'b1;
                    answer_next = 1'b0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.init_p = 1'b1;
                    // An odd sum of two primes must use two, so only n - 2 is tested.
                    state_next = status.n_odd ? S_LOAD_V2 : S_LOAD_V1;
                end
            end
            S_LOAD_V1:
            begin
                cmd.load_v_p = 1'b1;
                second_next  = 1'b0;
                state_next   = S_TEST;
            end
            S_LOAD_V2:
            begin
                cmd.load_v_np = 1'b1;
                second_next   = 1'b1;
                state_next    = S_TEST;
            end
            S_TEST:
            begin
                if (status.v_small)
                begin
                    is_composite = 1'b1;
                end
                else
                begin
                    cmd.init_div = 1'b1;
                    state_next   = S_BOUND;
                end
            end
            S_BOUND:
            begin
                if (status.sq_over)
                begin
                    is_prime = 1'b1;
                end
                else
                begin
                    cmd.start_rem = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.step_rem = 1'b1;
                if (status.rem_last)
                begin
                    state_next = S_REM_CHK;
                end
            end
            S_REM_CHK:
            begin
                if (status.rem_zero)
                begin
                    is_composite = 1'b1;
                end
                else
                begin
                    cmd.next_div = 1'b1;
                    state_next   = S_BOUND;
                end
            end
            S_NEXT_P:
            begin
                if (status.p_end)
                begin
                    done_next   = 1'b1;
                    answer_next = 1'b0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_LOAD_V1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (is_prime)
        begin
            if (second_reg)
            begin
                done_next   = 1'b1;
                answer_next = 1'b1;
                state_next  = S_IDLE;
            end
            else
            begin
                state_next = S_LOAD_V2;
            end
        end
        if (is_composite)
        begin
            if (status.n_odd)
            begin
                done_next   = 1'b1;
                answer_next = 1'b0;
                state_next  = S_IDLE;
            end
            else
            begin
                cmd.inc_p  = 1'b1;
                state_next = S_NEXT_P;
            end
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign answer = answer_reg;

endmodule

@@ src/two_prime_sum_check_core.sv @@
// Decides whether an unsigned number n is the sum of two primes.
// Request channel: target_number is taken at a rising edge where start is
// high and busy is low. busy stays high while the search runs; one request
// is worked on at a time.
// Result channel: done pulses high for exactly one cycle with
// is_two_prime_sum valid alongside it. The receiver cannot stall, so the
// result must be captured in that cycle. busy falls in the same cycle as
// done, so a new request may be issued while the result is shown.
// Sequence: n below four is rejected in the classify step. Otherwise, after
// classify, each primality test of a value v loads and screens it, then for
// each trial divisor does a bound compare, one restoring remainder step per
// value bit and a zero check, plus one more bound compare when v turns out
// prime. Odd n needs one test of n - 2; even n tests p and n - p for each
// candidate p until a prime pair is found or p passes n - 2, advancing p
// between candidates. done rises the cycle after the final decision.
// The shared bit-serial remainder unit sets the rate.
// Reset clears the controller to idle with no result pending; no clearing
// pass is needed.
module two_prime_sum_check_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tps_pkg::IN_BITS-1:0] target_number,
    output logic                        busy,
    output logic                        done,
    output logic                        is_two_prime_sum
);
    import tps_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tps_control u_control (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .answer (is_two_prime_sum)
    );

    tps_datapath u_datapath (
        .clk           (clk),
        .target_number (target_number),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

@@ sim/testbench.sv @@
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import tps_pkg::*;

    localparam time         CLK_PERIOD     = 10ns;
    localparam int unsigned RESET_CYCLES   = 4;
    localparam int unsigned WATCHDOG_LIMIT = 500000;
    localparam int unsigned TAIL_CYCLES    = 20;
    localparam int unsigned GAP_PERCENT    = 37;
    localparam int unsigned RANDOM_ITEMS   = 80;

    typedef struct {
        logic [IN_BITS-1:0] number;
        logic               answer;
    } pending_answer_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               start         = 1'b0;
    logic [IN_BITS-1:0] target_number = '0;
    logic               busy;
    logic               done;
    logic               is_two_prime_sum;

    pending_answer_t pending_answers[$];
    int unsigned     mismatch_count = 0;
    int unsigned     quiet_cycles   = 0;
    bit              steady_sender  = 1'b0;

    two_prime_sum_check_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .target_number    (target_number),
        .busy             (busy),
        .done             (done),
        .is_two_prime_sum (is_two_prime_sum)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic bit value_is_prime(input longint unsigned value);
        longint unsigned divisor;
        if (value < 2)
            return 1'b0;
        for (divisor = 2; divisor * divisor <= value; divisor++)
        begin
            if (value % divisor == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic predict_two_prime_sum(input logic [IN_BITS-1:0] raw);
        longint unsigned n;
        longint unsigned p;
        n = longint'(raw) & ((64'd1 << VALUE_BITS) - 1);
        if (n < 4)
            return 1'b0;
        // An odd sum of two primes must use the even prime two.
        if (n[0])
            return value_is_prime(n - 2);
        for (p = 2; p <= n - 2; p++)
        begin
            if (value_is_prime(p) && value_is_prime(n - p))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [IN_BITS-1:0] number,
                                   input logic got, input logic want);
        $display("MISMATCH %s: n=%0d got %b want %b at %0t", what, number, got, want, $realtime);
        mismatch_count++;
    endtask

    // Results are compared before a request taken at the same edge is queued.
    always @(posedge clk)
    begin
        pending_answer_t oldest;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_answers.size() == 0)
                    report_mismatch("result with no request outstanding", '0,
                                    is_two_prime_sum, 1'bx);
                else
                begin
                    oldest = pending_answers.pop_front();
                    if (is_two_prime_sum !== oldest.answer)
                        report_mismatch("is_two_prime_sum", oldest.number,
                                        is_two_prime_sum, oldest.answer);
                end
            end
            if (start && !busy)
                pending_answers.push_back('{target_number,
                                            predict_two_prime_sum(target_number)});
            if (done || (start && !busy))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog: no progress for %0d cycles", quiet_cycles);
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    // Leaves start high on return, so a following request can go out at once.
    task automatic send_request(input logic [IN_BITS-1:0] value);
        start         <= 1'b1;
        target_number <= value;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_off(input int unsigned cycles);
        start         <= 1'b0;
        target_number <= IN_BITS'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_hold_off();
        if (!steady_sender && $urandom_range(99) < GAP_PERCENT)
            hold_off($urandom_range(1, 30));
    endtask

    task automatic paced_request(input logic [IN_BITS-1:0] value);
        maybe_hold_off();
        send_request(value);
    endtask

    // Sampled on the falling edge so that the queue is settled when read.
    task automatic wait_until_answered();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_answers.size() != 0);
        @(posedge clk);
    endtask

    task automatic apply_reset();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    task automatic test_small_numbers();
        for (int unsigned n = 0; n < 10; n++)
            paced_request(IN_BITS'(n));
    endtask

    task automatic test_field_extremes();
        paced_request(16'hFFFF);
        paced_request(16'hFFFE);
        paced_request(16'h8000);
        paced_request(16'h7FFF);
        paced_request(16'hAAAA);
        paced_request(16'h5555);
    endtask

    task automatic test_odd_numbers();
        // Odd values where n - 2 is composite and where it is prime.
        paced_request(16'd11);
        paced_request(16'd13);
        paced_request(16'd27);
        paced_request(16'd65523);
    endtask

    task automatic test_pause_until_answered();
        steady_sender = 1'b1;
        send_request(16'd100);
        send_request(16'd101);
        send_request(16'd3);
        wait_until_answered();
        send_request(16'd2);
        steady_sender = 1'b0;
    endtask

    task automatic test_random_numbers();
        int unsigned        kind;
        logic [IN_BITS-1:0] value;
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            // The first stretch keeps start high throughout.
            steady_sender = (i < 25);
            kind = $urandom_range(99);
            if (kind < 35)
                value = IN_BITS'($urandom_range(0, 300));
            else if (kind < 55)
                value = IN_BITS'($urandom_range(5, 2001)) | 16'h0001;
            else if (kind < 85)
                value = IN_BITS'($urandom);
            else
                value = IN_BITS'(1 << $urandom_range(IN_BITS - 1))
                        | IN_BITS'($urandom_range(0, 63));
            paced_request(value);
        end
        steady_sender = 1'b0;
    endtask

    initial
    begin
        apply_reset();
        test_small_numbers();
        test_field_extremes();
        test_odd_numbers();
        test_pause_until_answered();
        test_random_numbers();
        wait_until_answered();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
